// ===== hw/rtl/rrjs_pkg.sv =====
`timescale 1ns / 1ps

package rrjs_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_NEW_JOB  = 4'd1,
    ST_NO_JOB   = 4'd2,
    ST_ANOTHER  = 4'd3,
    ST_COMPLETE = 4'd4,
    ST_RENEW    = 4'd5,
    ST_EXPIRED  = 4'd6,
    ST_ADDED    = 4'd7,
    ST_FULL     = 4'd8
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  localparam int unsigned IdW        = 8;
  localparam int unsigned FieldTimeW = 16;
  localparam int unsigned CountW     = 5;
  localparam int unsigned QuantumW   = 8;
  localparam logic [QuantumW-1:0] QuantumReset = 8'd4;

endpackage

// ===== hw/rtl/rrjs_ctrl.sv =====
`timescale 1ns / 1ps

module rrjs_ctrl
  import rrjs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output ctrl_cmd_t  cmd_o
);

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The output slot is free when empty or when its transaction completes now.
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !m_tready_i;
    s_tready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.capture = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign m_tvalid_o = out_valid_q;

`ifndef SYNTH
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!m_tvalid_o || m_tready_i))
    else $error("result committed over a pending result");

  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == FSM_EXEC))
    else $error("accepted item did not move to execution");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> m_tvalid_o)
    else $error("committed result not presented");

  a_no_capture_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_EXEC) |-> !cmd_o.capture)
    else $error("item accepted while another is in execution");
`endif

endmodule

// ===== hw/rtl/rrjs_dp.sv =====
`timescale 1ns / 1ps

module rrjs_dp
  import rrjs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_cmd_t                  cmd_i,
  input  logic [1:0]                 in_user_i,
  input  logic [39:0]                in_data_i,
  input  logic                       cfg_we_i,
  input  logic [QuantumW-1:0]        cfg_data_i,
  output logic [3:0]                 out_user_o,
  output logic [55:0]                out_data_o
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned EW = IdW + 2 * TB;

  // Wait queue entry: id in the top bits, then need, then executed time.
  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_q;
  logic          wr_en;
  logic [QW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [QuantumW-1:0] quantum_q;
  logic [QW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic                run_valid_q, run_valid_d;
  logic [IdW-1:0]      run_id_q, run_id_d;
  logic [TB-1:0]       run_need_q, run_need_d;
  logic [TB-1:0]       run_timer_q, run_timer_d;
  logic [QuantumW-1:0] slice_q, slice_d;
  status_e             status_q, status_d;

  logic [1:0]          cmd_q;
  logic [IdW-1:0]      job_id_q;
  logic [FieldTimeW-1:0] job_need_q;
  logic [FieldTimeW-1:0] job_exe_q;

  logic                fin;
  logic [IdW-1:0]      fin_id;
  logic [TB-1:0]       fin_exe;

  logic [QW:0]         tail_sum;
  logic [QW-1:0]       tail;
  logic [QW-1:0]       head_inc;
  logic [TB-1:0]       timer_inc;
  logic [QuantumW-1:0] slice_inc;
  logic                queue_nonempty;

  assign tail_sum = {1'b0, head_q} + (QW+1)'(count_q);
  assign tail     = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                    QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
  assign head_inc = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign timer_inc = (run_timer_q == '1) ? run_timer_q : run_timer_q + 1'b1;
  assign slice_inc = slice_q + 1'b1;
  assign queue_nonempty = (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q      <= in_user_i;
      job_id_q   <= in_data_i[7:0];
      job_need_q <= in_data_i[23:8];
      job_exe_q  <= in_data_i[39:24];
    end
  end

  // The head entry is read every cycle; it is settled by the time an item executes.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[head_q];
  end

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    run_valid_d = run_valid_q;
    run_id_d    = run_id_q;
    run_need_d  = run_need_q;
    run_timer_d = run_timer_q;
    slice_d     = slice_q;
    status_d    = status_q;
    wr_en       = 1'b0;
    wr_addr     = tail;
    wr_data     = {job_id_q, TB'(job_need_q), TB'(job_exe_q)};
    fin         = 1'b0;
    fin_id      = '0;
    fin_exe     = '0;
    unique case (cmd_q)
      CMD_ADD: begin
        if (count_q < CW'(QUEUE_DEPTH)) begin
          wr_en    = 1'b1;
          count_d  = count_q + 1'b1;
          status_d = ST_ADDED;
        end else begin
          status_d = ST_FULL;
        end
      end
      CMD_TICK: begin
        slice_d = '0;
        if (!run_valid_q) begin
          if (queue_nonempty) begin
            run_valid_d = 1'b1;
            run_id_d    = rd_q[EW-1 -: IdW];
            run_need_d  = rd_q[2*TB-1 -: TB];
            run_timer_d = rd_q[TB-1:0];
            head_d      = head_inc;
            count_d     = count_q - 1'b1;
            status_d    = ST_NEW_JOB;
          end else begin
            status_d = ST_NO_JOB;
          end
        end else if (timer_inc >= run_need_q) begin
          fin     = 1'b1;
          fin_id  = run_id_q;
          fin_exe = timer_inc;
          if (queue_nonempty) begin
            run_id_d    = rd_q[EW-1 -: IdW];
            run_need_d  = rd_q[2*TB-1 -: TB];
            run_timer_d = rd_q[TB-1:0];
            head_d      = head_inc;
            count_d     = count_q - 1'b1;
            status_d    = ST_ANOTHER;
          end else begin
            run_valid_d = 1'b0;
            run_id_d    = '0;
            run_need_d  = '0;
            run_timer_d = '0;
            status_d    = ST_COMPLETE;
          end
        end else if (slice_inc == quantum_q) begin
          status_d    = ST_EXPIRED;
          run_timer_d = timer_inc;
          if (queue_nonempty) begin
            // Rotation: the head job runs and the old job takes the tail slot.
            run_id_d    = rd_q[EW-1 -: IdW];
            run_need_d  = rd_q[2*TB-1 -: TB];
            run_timer_d = rd_q[TB-1:0];
            head_d      = head_inc;
            wr_en       = 1'b1;
            wr_data     = {run_id_q, run_need_q, timer_inc};
          end
        end else begin
          slice_d     = slice_inc;
          run_timer_d = timer_inc;
          status_d    = ST_RENEW;
        end
      end
      CMD_CLEAR: begin
        head_d      = '0;
        count_d     = '0;
        run_valid_d = 1'b0;
        run_id_d    = '0;
        run_need_d  = '0;
        run_timer_d = '0;
        slice_d     = '0;
        status_d    = ST_IDLE;
      end
      default: begin
      end
    endcase
    if (!cmd_i.commit) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= QuantumReset;
      head_q      <= '0;
      count_q     <= '0;
      run_valid_q <= 1'b0;
      run_id_q    <= '0;
      run_need_q  <= '0;
      run_timer_q <= '0;
      slice_q     <= '0;
      status_q    <= ST_IDLE;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        head_q      <= head_d;
        count_q     <= count_d;
        run_valid_q <= run_valid_d;
        run_id_q    <= run_id_d;
        run_need_q  <= run_need_d;
        run_timer_q <= run_timer_d;
        slice_q     <= slice_d;
        status_q    <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_user_o <= status_d;
      out_data_o <= {1'b0,
                     CountW'(count_d),
                     FieldTimeW'(fin_exe),
                     fin_id,
                     fin,
                     run_valid_d ? FieldTimeW'(run_timer_d) : {FieldTimeW{1'b0}},
                     run_valid_d ? run_id_d : {IdW{1'b0}},
                     run_valid_d};
    end
  end

endmodule

// ===== hw/rtl/round_robin_job_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Round-robin job scheduler: a FIFO wait queue and one running slot.
// Each command is registered in a capture step and then executed in a second step,
// which registers the result; a new command is taken only once the last one has
// executed, since the head-entry read of the queue memory is registered.
// Reset (asynchronous, active low) empties the queue and running slot and sets quantum to 4.

module round_robin_job_scheduler_unit
  import rrjs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // job_id, job_need_time, job_executed
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  // running_valid, running_job_id, running_executed, finished_valid,
  // finished_job_id, finished_executed, waiting_count, zero pad
  output logic [55:0] m_tdata,
  output logic [3:0]  m_tuser,   // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i // quantum
);

  ctrl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  rrjs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .cmd_o      (cmd)
  );

  rrjs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_user_i  (s_tuser),
    .in_data_i  (s_tdata),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_user_o (m_tuser),
    .out_data_o (m_tdata)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rrjs_pkg::*;

  localparam int unsigned QDepth        = 16;
  localparam logic [1:0]  CmdUnused     = 2'd3;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct {
    logic [7:0]  id;
    logic [15:0] need;
    logic [15:0] exe;
  } sched_job_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  id;
    logic [15:0] need;
    logic [15:0] exe;
  } sched_cmd_t;

  typedef struct {
    status_e     status;
    logic        run_v;
    logic [7:0]  run_id;
    logic [15:0] run_exe;
    logic        fin_v;
    logic [7:0]  fin_id;
    logic [15:0] fin_exe;
    logic [4:0]  waiting;
  } sched_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // job_id, job_need_time, job_executed
  logic [1:0]  s_tuser = '0;  // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // running_valid, running_job_id, running_executed, finished_valid,
  // finished_job_id, finished_executed, waiting_count, zero pad
  logic [55:0] m_tdata;
  logic [3:0]  m_tuser;       // status
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  round_robin_job_scheduler_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Scheduler state as the testbench tracks it.
  sched_job_t    wait_jobs[$];
  sched_job_t    run_job;
  logic          run_on = 1'b0;
  logic [7:0]    slice_cnt = '0;
  status_e       last_st = ST_IDLE;
  logic [7:0]    quant_q = QuantumReset;

  sched_cmd_t    pending_cmds[$];
  sched_report_t expected_reports[$];
  int unsigned   cmds_queued = 0;
  int unsigned   cmds_taken = 0;
  int unsigned   err_count = 0;

  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;
  int unsigned   hold_left = 0;
  int unsigned   hold_requests = 0;
  int unsigned   holds_served = 0;
  int unsigned   mode_left = 0;
  int unsigned   stall_pct = 0;
  int unsigned   idle_cycles = 0;

  task automatic predict_schedule(input logic [1:0] cmd, input logic [7:0] id,
                                  input logic [15:0] nd, input logic [15:0] ex,
                                  output sched_report_t rep);
    sched_job_t job;
    rep.fin_v   = 1'b0;
    rep.fin_id  = '0;
    rep.fin_exe = '0;
    case (cmd)
      CMD_ADD: begin
        if (wait_jobs.size() < QDepth) begin
          job.id   = id;
          job.need = nd;
          job.exe  = ex;
          wait_jobs.insert(wait_jobs.size(), job);
          last_st = ST_ADDED;
        end else begin
          last_st = ST_FULL;
        end
      end
      CMD_TICK: begin
        if (!run_on) begin
          if (wait_jobs.size() != 0) begin
            run_job = wait_jobs[0];
            wait_jobs.delete(0);
            run_on  = 1'b1;
            last_st = ST_NEW_JOB;
          end else begin
            last_st = ST_NO_JOB;
          end
          slice_cnt = '0;
        end else begin
          // The executed count saturates instead of wrapping.
          if (run_job.exe != 16'hFFFF) run_job.exe = run_job.exe + 16'd1;
          if (run_job.exe >= run_job.need) begin
            rep.fin_v   = 1'b1;
            rep.fin_id  = run_job.id;
            rep.fin_exe = run_job.exe;
            run_on = 1'b0;
            if (wait_jobs.size() != 0) begin
              run_job = wait_jobs[0];
              wait_jobs.delete(0);
              run_on  = 1'b1;
              last_st = ST_ANOTHER;
            end else begin
              last_st = ST_COMPLETE;
            end
            slice_cnt = '0;
          end else begin
            slice_cnt = slice_cnt + 8'd1;
            if (slice_cnt == quant_q) begin
              // With an empty queue the same job simply starts a new slice.
              if (wait_jobs.size() != 0) begin
                job     = run_job;
                run_job = wait_jobs[0];
                wait_jobs.delete(0);
                wait_jobs.insert(wait_jobs.size(), job);
              end
              slice_cnt = '0;
              last_st   = ST_EXPIRED;
            end else begin
              last_st = ST_RENEW;
            end
          end
        end
      end
      CMD_CLEAR: begin
        wait_jobs.delete();
        run_on    = 1'b0;
        slice_cnt = '0;
        last_st   = ST_IDLE;
      end
      default: begin
      end
    endcase
    rep.status  = last_st;
    rep.run_v   = run_on;
    rep.run_id  = run_on ? run_job.id : 8'd0;
    rep.run_exe = run_on ? run_job.exe : 16'd0;
    rep.waiting = 5'(wait_jobs.size());
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin : cmd_driver
    sched_cmd_t it;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        it = pending_cmds[0];
        pending_cmds.delete(0);
        s_tvalid <= 1'b1;
        s_tdata  <= {it.exe, it.need, it.id};
        s_tuser  <= it.cmd;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                     : $urandom_range(0, 3);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : report_sink
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= HoldCycles;
      m_tready     <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pct <= 0;
          2:       stall_pct <= 25;
          3:       stall_pct <= 50;
          default: stall_pct <= 80;
        endcase
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    sched_report_t exp_r;
    sched_report_t got_r;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) quant_q = cfg_data_i;
      if (s_tvalid && s_tready) begin
        predict_schedule(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[39:24], exp_r);
        expected_reports.insert(expected_reports.size(), exp_r);
        cmds_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d, data %h",
                   $time, m_tuser, m_tdata);
          err_count++;
        end else begin
          exp_r = expected_reports[0];
          expected_reports.delete(0);
          got_r.status  = status_e'(m_tuser);
          got_r.run_v   = m_tdata[0];
          got_r.run_id  = m_tdata[8:1];
          got_r.run_exe = m_tdata[24:9];
          got_r.fin_v   = m_tdata[25];
          got_r.fin_id  = m_tdata[33:26];
          got_r.fin_exe = m_tdata[49:34];
          got_r.waiting = m_tdata[54:50];
          check_field("status", exp_r.status, got_r.status);
          check_field("running_valid", exp_r.run_v, got_r.run_v);
          check_field("running_job_id", exp_r.run_id, got_r.run_id);
          check_field("running_executed", exp_r.run_exe, got_r.run_exe);
          check_field("finished_valid", exp_r.fin_v, got_r.fin_v);
          check_field("finished_job_id", exp_r.fin_id, got_r.fin_id);
          check_field("finished_executed", exp_r.fin_exe, got_r.fin_exe);
          check_field("waiting_count", exp_r.waiting, got_r.waiting);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] c, input logic [7:0] id,
                           input logic [15:0] nd, input logic [15:0] ex);
    sched_cmd_t it;
    it.cmd  = c;
    it.id   = id;
    it.need = nd;
    it.exe  = ex;
    pending_cmds.insert(pending_cmds.size(), it);
    cmds_queued++;
  endtask

  // Non-add commands carry random payload so that every data bit toggles.
  task automatic queue_plain(input logic [1:0] c);
    queue_cmd(c, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic queue_random_add();
    logic [15:0] nd;
    logic [15:0] ex;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      nd = 16'($urandom_range(1, 10));
      ex = 16'($urandom_range(0, 2));
    end else if (sel < 85) begin
      nd = 16'($urandom_range(1, 40));
      ex = 16'($urandom_range(0, 60));
    end else if (sel < 95) begin
      nd = 16'($urandom);
      ex = 16'($urandom);
    end else begin
      nd = '0;
      ex = 16'($urandom_range(0, 3));
    end
    queue_cmd(CMD_ADD, 8'($urandom), nd, ex);
  endtask

  // Mostly adds and ticks in a random ratio, with rare clears and unused codes.
  task automatic queue_random_mix(input int unsigned n);
    int unsigned add_pm;
    int unsigned r;
    case ($urandom_range(0, 2))
      0:       add_pm = 150;
      1:       add_pm = 350;
      default: add_pm = 550;
    endcase
    repeat (n) begin
      r = $urandom_range(0, 999);
      if (r < 8) queue_plain(CMD_CLEAR);
      else if (r < 20) queue_plain(CmdUnused);
      else if (r < 20 + add_pm) queue_random_add();
      else queue_plain(CMD_TICK);
    end
  endtask

  task automatic wait_quiet();
    while (cmds_taken != cmds_queued || expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [7:0] q);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= q;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset quantum of four.
    queue_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);   // nothing to run
    queue_cmd(CmdUnused, 8'hFF, 16'hFFFF, 16'hFFFF);  // repeats the last status
    queue_cmd(CMD_ADD, 8'h00, 16'h0000, 16'h0000);    // need met before it starts
    queue_cmd(CMD_ADD, 8'hFF, 16'hFFFF, 16'hFFFF);    // timer already at its maximum
    queue_cmd(CMD_ADD, 8'hA5, 16'h0003, 16'h0000);
    queue_cmd(CMD_ADD, 8'h3C, 16'h0002, 16'h0009);    // executed already past need
    repeat (4) queue_plain(CMD_TICK);
    queue_cmd(CMD_ADD, 8'h5A, 16'hFFFF, 16'h8000);    // added while a job runs
    repeat (3) queue_plain(CMD_TICK);
    repeat (5) queue_plain(CMD_TICK);                 // expiry with an empty queue
    queue_plain(CMD_CLEAR);
    queue_plain(CmdUnused);
    queue_plain(CMD_TICK);

    // Quantum of one; fill the queue past full, then hold off the receiver.
    wait_quiet();
    write_quantum(8'd1);
    queue_plain(CMD_CLEAR);
    repeat (18) queue_random_add();
    queue_random_mix(150);
    hold_requests++;

    // Largest quantum: one long job rotates behind a short one.
    wait_quiet();
    write_quantum(8'd255);
    queue_plain(CMD_CLEAR);
    queue_cmd(CMD_ADD, 8'($urandom), 16'd600, 16'd0);
    queue_cmd(CMD_ADD, 8'($urandom), 16'd5, 16'd0);
    repeat (260) queue_plain(CMD_TICK);
    queue_random_mix(100);

    // Quantum zero gives a 256-tick slice; the lone job keeps running.
    wait_quiet();
    write_quantum(8'd0);
    queue_plain(CMD_CLEAR);
    queue_cmd(CMD_ADD, 8'($urandom), 16'd400, 16'd0);
    repeat (270) queue_plain(CMD_TICK);
    queue_random_mix(80);

    for (int unsigned ph = 0; ph < 3; ph++) begin
      wait_quiet();
      write_quantum(8'($urandom_range(2, 8)));
      queue_random_mix(100);
      if (ph == 1) hold_requests++;
    end

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
